// ===== hw/rtl/b7enc_pkg.sv =====
// Shared types and constants for the byte to 7-bit packet encoder.
package b7enc_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned SYM_W  = 7;
    localparam int unsigned CNT_W  = 3;
    localparam int unsigned PEND_W = SYM_W - 1;
    localparam int unsigned BUF_W  = 2 * SYM_W;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SYM_W);

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_packet;
    } t_in_beat;

    typedef struct packed {
        logic [BYTE_W-1:0] symbol;
        logic              last_of_run;
    } t_out_beat;

    typedef struct packed {
        logic [BYTE_W-1:0] first;
        logic [BYTE_W-1:0] second;
        logic              two;
    } t_pack;

endpackage

// ===== hw/rtl/b7enc_pack.sv =====
// Leftover-bit state and the 8-to-7 bit repacking for one byte.
module b7enc_pack (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  b7enc_pkg::t_in_beat i_beat,
    output b7enc_pkg::t_pack    o_pack
);

    logic [b7enc_pkg::PEND_W-1:0] r_bits;
    logic [b7enc_pkg::CNT_W-1:0]  r_cnt;
    logic [b7enc_pkg::PEND_W-1:0] n_bits;
    logic [b7enc_pkg::CNT_W-1:0]  n_cnt;

    logic [b7enc_pkg::BUF_W-1:0]  buf_w;
    logic [b7enc_pkg::SYM_W-1:0]  rest;
    logic [b7enc_pkg::CNT_W-1:0]  new_cnt;
    logic                         two;

    always_comb begin
        buf_w   = (b7enc_pkg::BUF_W'(i_beat.data_byte) << r_cnt)
                | b7enc_pkg::BUF_W'(r_bits);
        rest    = buf_w[b7enc_pkg::BUF_W-1:b7enc_pkg::SYM_W];
        new_cnt = r_cnt + 1'b1;
        two     = i_beat.end_of_packet || (new_cnt == b7enc_pkg::CNT_FULL);

        o_pack.first  = {1'b0, buf_w[b7enc_pkg::SYM_W-1:0]};
        o_pack.second = {i_beat.end_of_packet, rest};
        o_pack.two    = two;

        n_bits = r_bits;
        n_cnt  = r_cnt;
        if (i_load) begin
            if (two) begin
                n_bits = '0;
                n_cnt  = '0;
            end else begin
                n_bits = rest[b7enc_pkg::PEND_W-1:0];
                n_cnt  = new_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
            r_cnt  <= '0;
        end else begin
            r_bits <= n_bits;
            r_cnt  <= n_cnt;
        end
    end

endmodule

// ===== hw/rtl/byte_to_7bit_packet_encoder_unit.sv =====
// Top level of the byte to 7-bit packet encoder.
//
// Input channel: i_in_valid / o_in_stall carry one byte per beat with an
// end-of-packet flag. Output channel: o_out_valid / i_out_stall carry one
// 7-bit symbol per beat; bit 7 of the symbol marks a packet's final symbol,
// and last_of_run marks the last symbol made from a given byte.
// Bytes are repacked LSB first; each byte makes one symbol, or two when it
// ends a packet or when seven leftover bits have built up.
// The first symbol of a byte is offered once the byte has passed the input
// register, then the result register. Throughput: one byte per cycle for
// bytes that make one symbol while the output does not stall; a byte that
// makes two holds back the next byte while its two symbols drain, set by
// the single symbol-per-cycle output port and its two-entry result buffer.
// A byte sits in the input register until the result buffer can take all
// of its symbols, so a stall on the output backs up combinationally into
// o_in_stall; no beat is dropped or repeated.
// Reset clears the leftover bits, their count, and all valid flags; the
// block is ready for a byte as soon as reset is released.
module byte_to_7bit_packet_encoder_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  b7enc_pkg::t_in_beat  i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output b7enc_pkg::t_out_beat o_out_beat
);

    logic                 r_iv;
    b7enc_pkg::t_in_beat  r_in;
    logic                 r_v0;
    logic                 r_v1;
    b7enc_pkg::t_out_beat r_o0;
    b7enc_pkg::t_out_beat r_o1;

    b7enc_pkg::t_pack     pack;
    logic                 in_take;
    logic                 out_take;
    logic                 ld_ok;
    logic                 load;

    assign out_take   = r_v0 && !i_out_stall;
    assign ld_ok      = !r_v1 && (!r_v0 || out_take);
    assign load       = r_iv && ld_ok;
    assign o_in_stall = r_iv && !ld_ok;
    assign in_take    = i_in_valid && !o_in_stall;

    assign o_out_valid = r_v0;
    assign o_out_beat  = r_o0;

    b7enc_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_beat  (r_in),
        .o_pack  (pack)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (in_take) begin
            r_iv <= 1'b1;
        end else if (load) begin
            r_iv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (load) begin
            r_v0 <= 1'b1;
            r_v1 <= pack.two;
        end else if (out_take) begin
            r_v0 <= r_v1;
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o0.symbol      <= pack.first;
            r_o0.last_of_run <= !pack.two;
            r_o1.symbol      <= pack.second;
            r_o1.last_of_run <= 1'b1;
        end else if (out_take) begin
            r_o0 <= r_o1;
        end
    end

`ifndef SYNTHESIS
    a_slot_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> r_v0)
        else $error("second slot valid without first slot");

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_iv && !ld_ok) |=> (r_iv && $stable(r_in)))
        else $error("pending byte lost while result buffer full");

    a_first_has_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v0 && !r_o0.last_of_run) |-> r_v1)
        else $error("first of two symbols shown without its successor");

    a_end_flag_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v0 && r_o0.symbol[b7enc_pkg::SYM_W]) |-> r_o0.last_of_run)
        else $error("end flag on a symbol that is not last of its run");
`endif

endmodule

// ===== tb/byte_to_7bit_packet_encoder_unit_tb.sv =====
// Self-checking testbench for the byte to 7-bit packet encoder: predicts every symbol beat.
`timescale 1ns / 1ps

module byte_to_7bit_packet_encoder_unit_tb;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 11;
    localparam int TIMEOUT_CYCLES = 600_000;
    localparam int LONG_HOLD      = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam logic [b7enc_pkg::BYTE_W-1:0] FINAL_FLAG = 8'h80;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    b7enc_pkg::t_in_beat  i_in_beat   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    b7enc_pkg::t_out_beat o_out_beat;

    logic [b7enc_pkg::SYM_W-1:0] carry_bits  = '0;
    logic [b7enc_pkg::CNT_W-1:0] carry_count = '0;
    b7enc_pkg::t_out_beat        expected_symbols[$];
    int                          n_errors       = 0;
    int                          n_sent         = 0;
    int                          rx_hold_cycles = 0;
    bit                          quiet          = 1'b0;

    byte_to_7bit_packet_encoder_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic void encode_byte(b7enc_pkg::t_in_beat beat);
        logic [b7enc_pkg::BUF_W-1:0] merged;
        logic [b7enc_pkg::CNT_W-1:0] next_count;
        b7enc_pkg::t_out_beat        sym;
        merged     = b7enc_pkg::BUF_W'(carry_bits)
                   | (b7enc_pkg::BUF_W'(beat.data_byte) << carry_count);
        next_count = carry_count + 1'b1;
        sym.symbol = {1'b0, merged[b7enc_pkg::SYM_W-1:0]};
        if (beat.end_of_packet || next_count == b7enc_pkg::CNT_FULL) begin
            sym.last_of_run = 1'b0;
            expected_symbols.push_back(sym);
            sym.symbol = {1'b0, merged[b7enc_pkg::BUF_W-1:b7enc_pkg::SYM_W]};
            if (beat.end_of_packet) begin
                sym.symbol = sym.symbol | FINAL_FLAG;
            end
            sym.last_of_run = 1'b1;
            expected_symbols.push_back(sym);
            carry_bits  = '0;
            carry_count = '0;
        end else begin
            sym.last_of_run = 1'b1;
            expected_symbols.push_back(sym);
            carry_bits  = merged[b7enc_pkg::BUF_W-1:b7enc_pkg::SYM_W];
            carry_count = next_count;
        end
    endfunction

    task automatic send_byte(input logic [b7enc_pkg::BYTE_W-1:0] data, input logic eop);
        int                  gap;
        b7enc_pkg::t_in_beat beat;
        beat.data_byte     = data;
        beat.end_of_packet = eop;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_beat  <= beat;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        encode_byte(beat);
        n_sent++;
    endtask

    task automatic send_packet(input int len);
        for (int i = 0; i < len; i++) begin
            send_byte(b7enc_pkg::BYTE_W'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    task automatic drain_symbols();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_symbols.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed_extremes();
        logic [b7enc_pkg::BYTE_W-1:0] run_bytes [7] =
            '{8'hFF, 8'h00, 8'hAA, 8'h55, 8'h01, 8'h7F, 8'hFE};
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h80, 1'b1);
        // fill the carry to a full symbol without ending the packet
        foreach (run_bytes[i]) send_byte(run_bytes[i], 1'b0);
        // fill it again, ending the packet on the seventh byte
        foreach (run_bytes[i]) send_byte(~run_bytes[i], i == 6);
        send_byte(8'h81, 1'b0);
        send_byte(8'h7E, 1'b0);
        send_byte(8'hC3, 1'b1);
    endtask

    task automatic test_random_packets();
        while (n_sent < 1170) begin
            if ($urandom_range(0, 7) == 0) begin
                send_byte(b7enc_pkg::BYTE_W'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
            end else if ($urandom_range(0, 3) == 0) begin
                send_packet($urandom_range(7, 30));
            end else begin
                send_packet($urandom_range(1, 8));
            end
        end
    endtask

    task automatic test_output_backpressure();
        rx_hold_cycles = LONG_HOLD;
        repeat (4) send_packet($urandom_range(10, 25));
    endtask

    task automatic test_drain_between_packets();
        repeat (8) begin
            send_packet($urandom_range(1, 14));
            drain_symbols();
        end
    endtask

    task automatic test_quiet_tail();
        quiet = 1'b1;
        while (n_sent < 1550) send_packet($urandom_range(1, 14));
    endtask

    initial begin : drive_out_stall
        int burst;
        burst = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                rx_hold_cycles--;
                i_out_stall <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                i_out_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 18) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : check_symbols
        b7enc_pkg::t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_symbols.size() == 0) begin
                $error("unexpected symbol beat: symbol %02h last_of_run %0b",
                       o_out_beat.symbol, o_out_beat.last_of_run);
                n_errors++;
            end else begin
                want = expected_symbols.pop_front();
                if (o_out_beat.symbol !== want.symbol) begin
                    $error("symbol: expected %02h, actual %02h",
                           want.symbol, o_out_beat.symbol);
                    n_errors++;
                end
                if (o_out_beat.last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %0b, actual %0b",
                           want.last_of_run, o_out_beat.last_of_run);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_extremes();
        test_random_packets();
        test_output_backpressure();
        test_drain_between_packets();
        test_quiet_tail();
        drain_symbols();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("byte_to_7bit_packet_encoder_unit_tb: PASS");
        end else begin
            $display("byte_to_7bit_packet_encoder_unit_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #(2 * CLK_HALF * TIMEOUT_CYCLES);
        $display("byte_to_7bit_packet_encoder_unit_tb: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/b7enc_pkg.sv
hw/rtl/b7enc_pack.sv
hw/rtl/byte_to_7bit_packet_encoder_unit.sv
tb/byte_to_7bit_packet_encoder_unit_tb.sv
